// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- rtl/stip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types and character constants of the string-to-integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

    localparam int CH_W        = 8;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 4;
    localparam int VALUE_OUT_W = 64;
    localparam int CONSUMED_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

    localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

    // Classified byte handed from the front end to the back end
    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] radix;
        logic               is_ws;
        logic               is_sign;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               dig_ok;
        logic [DIGIT_W-1:0] dig;
    } cls_t;

    // One finished result
    typedef struct packed {
        logic [VALUE_OUT_W-1:0] value;
        logic [CONSUMED_W-1:0]  consumed;
    } res_t;

endpackage

// ----- rtl/stip_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module stip_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == NW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/stip_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_front
// Accept text bytes, classify them and queue them for the back end.
// ----------------------------------------------------------------------------
module stip_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [stip_pkg::CH_W-1:0]      ch,
    input  logic                           start_req,
    input  logic [stip_pkg::RADIX_W-1:0]   radix,
    output logic                           full,
    input  logic                           take,
    output stip_pkg::cls_t                 item,
    output logic                           item_valid
);

    stip_pkg::cls_t cls;
    logic           q_empty;

    always_comb
    begin
        cls           = '0;
        cls.start     = start_req;
        cls.radix     = radix;
        cls.is_ws     = (ch == stip_pkg::CH_SPACE) || (ch == stip_pkg::CH_TAB);
        cls.is_sign   = (ch == stip_pkg::CH_MINUS) || (ch == stip_pkg::CH_PLUS);
        cls.is_minus  = (ch == stip_pkg::CH_MINUS);
        cls.is_zero   = (ch == stip_pkg::CH_0);
        cls.is_x      = (ch == stip_pkg::CH_LX) || (ch == stip_pkg::CH_UX);
        case (ch) inside
            [stip_pkg::CH_0:stip_pkg::CH_9]:
            begin
                cls.dig_ok = 1'b1;
                cls.dig    = stip_pkg::DIGIT_W'(ch - stip_pkg::CH_0);
            end
            [stip_pkg::CH_LA:stip_pkg::CH_LF]:
            begin
                cls.dig_ok = 1'b1;
                cls.dig    = stip_pkg::DIGIT_W'(ch - stip_pkg::CH_LA) + 4'd10;
            end
            [stip_pkg::CH_UA:stip_pkg::CH_UF]:
            begin
                cls.dig_ok = 1'b1;
                cls.dig    = stip_pkg::DIGIT_W'(ch - stip_pkg::CH_UA) + 4'd10;
            end
            default:
            begin
                cls.dig_ok = 1'b0;
                cls.dig    = '0;
            end
        endcase
    end

    stip_fifo #(
        .WIDTH ($bits(stip_pkg::cls_t)),
        .DEPTH (stip_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (take),
        .rdata (item),
        .empty (q_empty)
    );

    assign item_valid = !q_empty;

endmodule

// ----- rtl/stip_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_back
// Run the parse sequence on classified bytes and produce results.
// ----------------------------------------------------------------------------
module stip_back #(
    parameter int VALUE_WIDTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  stip_pkg::cls_t item,
    input  logic           item_valid,
    output logic           take,
    input  logic           res_full,
    output logic           res_push,
    output stip_pkg::res_t res
);

    localparam int RW = stip_pkg::RADIX_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        PH_DONE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_XSEEN,
        PH_DIGITS
    } phase_t;

    phase_t                  phase_reg, phase_next, ph_e;
    logic [RW-1:0]           base_reg, base_next, base_e, base_d;
    logic                    neg_reg, neg_next, neg_e;
    logic [VALUE_WIDTH-1:0]  acc_reg, acc_next, acc_e, val_w;
    logic [COUNT_WIDTH-1:0]  cnt_reg, cnt_next, cnt_e, cnt_inc, cnt_out;
    logic [VALUE_WIDTH+RW-1:0] prod;
    logic                    use_digit, xcorr, fire, pre_zero, dig_in_base;

    // A start byte restarts the parse before it is itself parsed
    assign ph_e    = item.start ? PH_LEAD : phase_reg;
    assign base_e  = item.start ? item.radix : base_reg;
    assign neg_e   = item.start ? 1'b0 : neg_reg;
    assign acc_e   = item.start ? '0 : acc_reg;
    assign cnt_e   = item.start ? '0 : cnt_reg;
    assign cnt_inc = (cnt_e == CNT_MAX) ? cnt_e : cnt_e + COUNT_WIDTH'(1);

    assign pre_zero = item.is_zero
                   && ((base_e == stip_pkg::BASE_AUTO) || (base_e == stip_pkg::BASE_HEX));

    // Base the digit stage obeys: detect mode settles on octal after a
    // leading zero and on decimal otherwise
    assign base_d = (base_e != stip_pkg::BASE_AUTO) ? base_e
                  : ((ph_e == PH_ZERO) ? stip_pkg::BASE_OCT : stip_pkg::BASE_DEC);

    always_comb
    begin
        phase_next = ph_e;
        base_next  = base_e;
        neg_next   = neg_e;
        acc_next   = acc_e;
        cnt_next   = cnt_e;
        use_digit  = 1'b0;
        xcorr      = 1'b0;
        fire       = 1'b0;
        case (ph_e)
            PH_LEAD, PH_SIGNED:
            begin
                if ((ph_e == PH_LEAD) && item.is_ws)
                begin
                    cnt_next = cnt_inc;
                end
                else if ((ph_e == PH_LEAD) && item.is_sign)
                begin
                    neg_next   = item.is_minus;
                    cnt_next   = cnt_inc;
                    phase_next = PH_SIGNED;
                end
                else if (pre_zero)
                begin
                    cnt_next   = cnt_inc;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    use_digit = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (item.is_x)
                begin
                    cnt_next   = cnt_inc;
                    base_next  = stip_pkg::BASE_HEX;
                    phase_next = PH_XSEEN;
                end
                else
                begin
                    use_digit = 1'b1;
                end
            end
            PH_XSEEN:
            begin
                use_digit = 1'b1;
                xcorr     = 1'b1;
            end
            PH_DIGITS:
            begin
                use_digit = 1'b1;
            end
            default:
            begin
                use_digit = 1'b0;
            end
        endcase

        if (use_digit)
        begin
            base_next = base_d;
            if (dig_in_base)
            begin
                acc_next   = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(item.dig);
                cnt_next   = cnt_inc;
                phase_next = PH_DIGITS;
            end
            else
            begin
                fire       = 1'b1;
                phase_next = PH_DONE;
            end
        end
    end

    assign dig_in_base = item.dig_ok && (RW'(item.dig) < base_d);
    assign prod        = (VALUE_WIDTH+RW)'(acc_e) * (VALUE_WIDTH+RW)'(base_d);

    // Stop byte: the value leaves unchanged, negated if a minus was seen
    assign val_w   = neg_e ? (VALUE_WIDTH'(0) - acc_e) : acc_e;
    assign cnt_out = (xcorr && (cnt_e != '0)) ? cnt_e - COUNT_WIDTH'(1) : cnt_e;

    assign take         = item_valid && !res_full;
    assign res_push     = take && fire;
    assign res.value    = stip_pkg::VALUE_OUT_W'($signed(val_w));
    assign res.consumed = stip_pkg::CONSUMED_W'(cnt_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            base_reg  <= stip_pkg::BASE_DEC;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- rtl/string_to_integer_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser_core
// Streaming strtol-style parser: text bytes in, signed value and count out.
// ----------------------------------------------------------------------------
// Usage:
//   Input side: an item (ch, start_req, radix) is taken at an edge where push
//   is high and full is low. Raise start_req on the first byte of each text;
//   radix is sampled there only. Output side: while empty is low, value and
//   consumed show the oldest result; pop takes it at an edge where empty is low.
//   One result leaves per text, on its stop byte (NUL or a non-digit); later
//   bytes are dropped until the next start.
// Timing:
//   One byte per cycle sustained while the result queue is not full. The front
//   end classifies and queues a byte; the back end takes it from that queue and
//   steps the parse with one 64-by-6 multiply-add. A result is registered in
//   the result queue before it shows. Each side has a two-item register queue.
// Reset and stalls:
//   rst_n clears both queues, parser done, base ten. A stalled result side
//   fills the result queue, then the byte queue, and then full rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module string_to_integer_parser_core #(
    parameter int VALUE_WIDTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [stip_pkg::CH_W-1:0]              ch,
    input  logic                                   start_req,
    input  logic [stip_pkg::RADIX_W-1:0]           radix,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [stip_pkg::VALUE_OUT_W-1:0] value,
    output logic [stip_pkg::CONSUMED_W-1:0]        consumed
);

    stip_pkg::cls_t item;
    stip_pkg::res_t res, res_head;
    logic           item_valid;
    logic           take;
    logic           res_push;
    logic           res_full;

    // Front: take and classify bytes
    stip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .ch         (ch),
        .start_req  (start_req),
        .radix      (radix),
        .full       (full),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    // Back: run the parse and emit one result per text
    stip_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .take       (take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res)
    );

    // Result queue: holds finished items while the receiver stalls
    stip_fifo #(
        .WIDTH ($bits(stip_pkg::res_t)),
        .DEPTH (stip_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign value    = res_head.value;
    assign consumed = res_head.consumed;

    `ASSERT_IMPLIES(a_res_no_overflow, clk, rst_n, res_push, !res_full)
    `ASSERT_IMPLIES(a_take_has_item, clk, rst_n, take, item_valid)
    `ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty)

endmodule
